// ===== hw/rtl/smx_pkg.sv =====
// ----------------------------------------------------------------------------
// smx_pkg
// shared types and constants of the stack machine execute block
// ----------------------------------------------------------------------------
package smx_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int NUM_REGS    = 8;
    localparam int RAM_WORDS   = 1024;

    localparam int SP_W   = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int REG_W  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int RAM_AW = $clog2(RAM_WORDS);

    typedef enum logic [3:0] {
        CMD_HALT = 4'd0,
        CMD_PSH  = 4'd1,
        CMD_POP  = 4'd2,
        CMD_ADD  = 4'd3,
        CMD_SUB  = 4'd4,
        CMD_MUL  = 4'd5,
        CMD_DIV  = 4'd6,
        CMD_OUT  = 4'd7,
        CMD_JLT  = 4'd8
    } cmd_t;

    typedef enum logic [2:0] {
        ERR_OK      = 3'd0,
        ERR_EMPTY   = 3'd1,
        ERR_FULL    = 3'd2,
        ERR_DIVZERO = 3'd3,
        ERR_ADDR    = 3'd4,
        ERR_CMD     = 3'd5
    } err_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

endpackage

// ===== hw/rtl/smx_div.sv =====
// ----------------------------------------------------------------------------
// smx_div
// signed 32-bit restoring divider, one quotient bit per cycle, truncating
// ----------------------------------------------------------------------------
module smx_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  smx_pkg::div_req_t req,
    output smx_pkg::div_rsp_t rsp
);
    import smx_pkg::*;

    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [31:0] ma;
    logic [31:0] mb;

    always_comb begin
        ma = req.dividend[31] ? (32'd0 - req.dividend) : req.dividend;
        mb = req.divisor[31] ? (32'd0 - req.divisor) : req.divisor;
        trial = {rem_reg, quo_reg[31]} - {1'b0, dvs_reg};
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next = 32'd0;
            quo_next = ma;
            dvs_next = mb;
            neg_next = req.dividend[31] ^ req.divisor[31];
            cnt_next = 6'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[32]) begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = {rem_reg[30:0], quo_reg[31]};
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (32'd0 - quo_reg) : quo_reg;

endmodule

// ===== hw/rtl/stack_machine_execute_top.sv =====
// ----------------------------------------------------------------------------
// stack_machine_execute_top
// executes one decoded stack machine instruction per transaction
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  s_      | in        | command option_bits immediate reg_index jump_target cur_addr
//  m_      | out       | next_addr out_valid out_value halted error_code
//
//  an instruction runs as fetch of the stack top, read of the second entry or
//  ram word, then execute and write back; div also waits on the bit-serial
//  divider. all 1024 ram words are cleared in turn after reset, during which
//  s_ready stays low. a finished result waits in the output register; the
//  next instruction is taken once it has been accepted.
module stack_machine_execute_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_command,
    input  logic [2:0]  s_option_bits,
    input  logic [31:0] s_immediate,
    input  logic [2:0]  s_reg_index,
    input  logic [15:0] s_jump_target,
    input  logic [15:0] s_cur_addr,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_next_addr,
    output logic        m_out_valid,
    output logic [31:0] m_out_value,
    output logic        m_halted,
    output logic [2:0]  m_error_code
);
    import smx_pkg::*;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_RD1   = 6'b000100,
        ST_RD2   = 6'b001000,
        ST_EXEC  = 6'b010000,
        ST_DIV   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] stack_mem [STACK_DEPTH];
    logic [31:0] ram_mem [RAM_WORDS];
    logic [31:0] regs_reg [NUM_REGS];

    logic [CNT_W-1:0]  cnt_reg;
    logic [RAM_AW:0]   clr_reg;
    logic [3:0]  cmd_reg;
    logic [2:0]  opt_reg;
    logic [31:0] imm_reg;
    logic [2:0]  ri_reg;
    logic [15:0] tgt_reg;
    logic [15:0] cur_reg;
    logic [31:0] top_reg;
    logic [31:0] sec_reg;
    logic [31:0] sum_reg;
    logic [31:0] stk_rd_reg;
    logic [31:0] ram_rd_reg;

    logic        st_we;
    logic [SP_W-1:0] st_wa;
    logic [31:0] st_wd;
    logic [SP_W-1:0] st_ra;
    logic        ram_we;
    logic [RAM_AW-1:0] ram_wa;
    logic [31:0] ram_wd;
    logic        reg_we;
    logic [15:0] nx;
    logic [2:0]  err;
    logic        ov;
    logic [31:0] oval;
    logic        hl;
    logic [CNT_W-1:0] cnt_new;
    logic        fin;
    logic [31:0] sum_c;
    logic        use_imm, use_ram, use_reg, is_pop_reg;
    logic [31:0] res;
    logic        take;
    logic        reg_ok;
    div_req_t    dreq;
    div_rsp_t    drsp;

    smx_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    assign use_imm    = opt_reg[0];
    assign use_reg    = opt_reg[1];
    assign use_ram    = opt_reg[2];
    assign is_pop_reg = (cmd_reg == CMD_POP) && !use_ram;
    assign reg_ok     = {29'd0, ri_reg} < NUM_REGS;
    assign sum_c      = (use_imm ? imm_reg : 32'd0)
                      + ((use_reg && reg_ok) ? regs_reg[ri_reg[REG_W-1:0]] : 32'd0);

    assign s_ready = (state_reg == ST_IDLE) && !m_valid;
    assign take    = s_valid && s_ready;

    always_comb begin
        st_ra = SP_W'(cnt_reg - CNT_W'(1));
        if (state_reg == ST_RD1) st_ra = SP_W'(cnt_reg - CNT_W'(2));
    end

    always_comb begin
        st_we = 1'b0; st_wa = SP_W'(cnt_reg); st_wd = 32'd0;
        ram_we = 1'b0; ram_wa = sum_reg[RAM_AW-1:0]; ram_wd = top_reg;
        reg_we = 1'b0;
        nx = cur_reg; err = ERR_OK; ov = 1'b0; oval = 32'd0; hl = 1'b0;
        cnt_new = cnt_reg; fin = 1'b0; res = 32'd0;
        dreq.start = 1'b0; dreq.dividend = sec_reg; dreq.divisor = top_reg;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we = 1'b1; ram_wa = clr_reg[RAM_AW-1:0]; ram_wd = 32'd0;
                if (clr_reg == (RAM_AW+1)'(RAM_WORDS - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: if (take) state_next = ST_RD1;
            ST_RD1:  state_next = ST_RD2;
            ST_RD2:  state_next = ST_EXEC;
            ST_EXEC, ST_DIV: begin
                fin = 1'b1;
                state_next = ST_IDLE;
                case (cmd_reg) inside
                    CMD_HALT: hl = 1'b1;
                    CMD_PSH, CMD_POP: begin
                        if (is_pop_reg) nx = cur_reg + 16'd3;
                        else nx = cur_reg + 16'd2 + {15'd0, use_imm} + {15'd0, use_reg};
                        if ((use_reg || is_pop_reg) && !reg_ok) err = ERR_ADDR;
                        else if (use_ram && sum_reg >= RAM_WORDS) err = ERR_ADDR;
                        else if (cmd_reg == CMD_PSH) begin
                            if (cnt_reg >= CNT_W'(STACK_DEPTH)) err = ERR_FULL;
                            else begin
                                st_we = 1'b1;
                                st_wd = use_ram ? ram_rd_reg : sum_reg;
                                cnt_new = cnt_reg + CNT_W'(1);
                            end
                        end else begin
                            if (cnt_reg == '0) err = ERR_EMPTY;
                            else begin
                                cnt_new = cnt_reg - CNT_W'(1);
                                if (use_ram) ram_we = 1'b1;
                                else reg_we = 1'b1;
                            end
                        end
                    end
                    CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                        nx = cur_reg + 16'd1;
                        if (cmd_reg == CMD_ADD) res = sec_reg + top_reg;
                        else if (cmd_reg == CMD_SUB) res = sec_reg - top_reg;
                        else if (cmd_reg == CMD_MUL) res = sec_reg * top_reg;
                        else res = drsp.quotient;
                        if (cnt_reg < CNT_W'(2)) err = ERR_EMPTY;
                        else if (cmd_reg == CMD_DIV && top_reg == 32'd0) err = ERR_DIVZERO;
                        else if (cmd_reg == CMD_DIV && state_reg == ST_EXEC) begin
                            fin = 1'b0; dreq.start = 1'b1; state_next = ST_DIV;
                        end else if (cmd_reg == CMD_DIV && !drsp.done) begin
                            fin = 1'b0; state_next = ST_DIV;
                        end
                        if (fin && err == ERR_OK) begin
                            st_we = 1'b1;
                            st_wa = SP_W'(cnt_reg - CNT_W'(2));
                            st_wd = res;
                            cnt_new = cnt_reg - CNT_W'(1);
                        end
                    end
                    CMD_OUT: begin
                        nx = cur_reg + 16'd1;
                        if (cnt_reg == '0) err = ERR_EMPTY;
                        else begin
                            ov = 1'b1; oval = top_reg;
                            cnt_new = cnt_reg - CNT_W'(1);
                        end
                    end
                    CMD_JLT: begin
                        nx = cur_reg + 16'd2;
                        if (cnt_reg < CNT_W'(2)) err = ERR_EMPTY;
                        else begin
                            cnt_new = cnt_reg - CNT_W'(2);
                            if ($signed(sec_reg) < $signed(top_reg)) nx = tgt_reg;
                        end
                    end
                    default: err = ERR_CMD;
                endcase
                if (!fin) begin
                    st_we = 1'b0; ram_we = 1'b0; reg_we = 1'b0; cnt_new = cnt_reg;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        stk_rd_reg <= stack_mem[st_ra];
        if (st_we) stack_mem[st_wa] <= st_wd;
    end

    always_ff @(posedge aclk) begin
        ram_rd_reg <= ram_mem[sum_c[RAM_AW-1:0]];
        if (ram_we) ram_mem[ram_wa] <= ram_wd;
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            cmd_reg <= s_command; opt_reg <= s_option_bits; imm_reg <= s_immediate;
            ri_reg <= s_reg_index; tgt_reg <= s_jump_target; cur_reg <= s_cur_addr;
        end
        if (state_reg == ST_RD1) begin
            sum_reg <= sum_c;
            top_reg <= stk_rd_reg;
        end
        if (state_reg == ST_RD2) sec_reg <= stk_rd_reg;
        if (fin) begin
            m_next_addr <= nx; m_out_valid <= ov; m_out_value <= oval;
            m_halted <= hl; m_error_code <= err;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            cnt_reg <= '0;
            clr_reg <= '0;
            m_valid <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++) regs_reg[i] <= 32'd0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_new;
            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + (RAM_AW+1)'(1);
            if (fin) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
            if (reg_we) regs_reg[ri_reg[REG_W-1:0]] <= top_reg;
        end
    end

    a_no_take_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready) else $error("ready while busy");
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(STACK_DEPTH)) else $error("stack count overrun");
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_next_addr)))
        else $error("result dropped");

endmodule
